// ----- sv/wgbu_pkg.sv -----
`default_nettype none
package wgbu_pkg;

    localparam int ONE_Q12 = 4096;
    localparam int RECIP_SHIFT = 20;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_INTERP = 1'b1;

    localparam logic [2:0] CFG_WINDOW_SIZE = 3'd0;
    localparam logic [2:0] CFG_HALF_WINDOW = 3'd1;
    localparam logic [2:0] CFG_NUM_LINES = 3'd2;
    localparam logic [2:0] CFG_NUM_SAMPS = 3'd3;
    localparam logic [2:0] CFG_INTERP_BIT = 3'd4;
    localparam logic [2:0] CFG_WATER_BIT = 3'd5;
    localparam logic [2:0] CFG_FILL_BIT = 3'd6;

    typedef enum logic [1:0] {
        KIND_INTERP = 2'd0,
        KIND_CENTER = 2'd1,
        KIND_FILL = 2'd2
    } t_kind;

    typedef struct packed {
        logic [15:0] value;
        logic [7:0] flag;
        t_kind kind;
    } t_res;

    // ceil(2^20 / ws) for ws 2..16, else 2^20; exact floor quotient for dividends below 2^16
    function automatic logic [20:0] recip(input logic [4:0] ws);
        logic [20:0] r;
        unique case (ws)
            5'd2: r = 21'd524288;
            5'd3: r = 21'd349526;
            5'd4: r = 21'd262144;
            5'd5: r = 21'd209716;
            5'd6: r = 21'd174763;
            5'd7: r = 21'd149797;
            5'd8: r = 21'd131072;
            5'd9: r = 21'd116509;
            5'd10: r = 21'd104858;
            5'd11: r = 21'd95326;
            5'd12: r = 21'd87382;
            5'd13: r = 21'd80660;
            5'd14: r = 21'd74899;
            5'd15: r = 21'd69906;
            5'd16: r = 21'd65536;
            default: r = 21'd1048576;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- sv/wgbu_if.sv -----
`default_nettype none
interface wgbu_in_if;
    logic valid;
    logic ready;
    logic operation;
    logic [11:0] line;
    logic [11:0] samp;
    logic pixel_is_fill;
    logic [15:0] center_value;
    logic [7:0] center_flag;

    modport source(output valid, operation, line, samp, pixel_is_fill, center_value,
                   center_flag, input ready);
    modport sink(input valid, operation, line, samp, pixel_is_fill, center_value,
                 center_flag, output ready);
endinterface

interface wgbu_out_if;
    logic valid;
    logic ready;
    logic [15:0] aerosol_value;
    logic [7:0] pixel_flag;
    logic [1:0] result_kind;

    modport source(output valid, aerosol_value, pixel_flag, result_kind, input ready);
    modport sink(input valid, aerosol_value, pixel_flag, result_kind, output ready);
endinterface
`default_nettype wire

// ----- sv/window_grid_bilinear_upsample_core.sv -----
// Window-grid bilinear upsampler.
// i_item carries load items (store a window center's value and flag) and
// interpolate items (one pixel's line, sample and fill bit); o_result carries
// one result for each interpolate item and nothing for loads.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must write it only while the block is idle, which the block does not enforce.
// Throughput: one item per cycle while the output queue is not full. The
// pipeline has 8 register stages (four reciprocal divides per axis, the grid
// read from four parity banks, two multiply stages).
// The grid sits in four banks split by cell row and column parity, so the
// four centers of a pixel are read in the same cycle.
// Reset restores the configuration defaults and empties the pipeline; the
// grid keeps whatever it held.
// A two-entry output queue absorbs a stalled receiver; the pipeline and
// i_item.ready hold only when that queue is full.
`default_nettype none
module window_grid_bilinear_upsample_core #(
    parameter int GRID_ROWS = 256,
    parameter int GRID_COLS = 256,
    parameter int VALUE_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [12:0] i_cfg_data,
    wgbu_in_if.sink          i_item,
    wgbu_out_if.source       o_result
);
    import wgbu_pkg::*;

    localparam int SB = (VALUE_BITS < 16) ? VALUE_BITS : 16;
    localparam int BW = SB + 8;
    localparam int RCW = $clog2(GRID_ROWS);
    localparam int CCW = $clog2(GRID_COLS);
    localparam int HR = (GRID_ROWS + 1) / 2;
    localparam int HC = (GRID_COLS + 1) / 2;
    localparam int BANK_DEPTH = HR * HC;
    localparam int AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int PW = 25 + SB;
    localparam int SW = PW + 2;

    logic [4:0] r_ws;
    logic [3:0] r_hw;
    logic [12:0] r_nl, r_ns;
    logic [2:0] r_ib, r_wb, r_fb;
    logic [4:0] ws_e;

    logic en, full;

    logic r0_v, r0_op, r0_fill;
    logic [11:0] r0_line, r0_samp;
    logic [15:0] r0_val;
    logic [7:0] r0_flag;

    logic r_v [1:4];
    logic r_op [1:4];
    logic r_fill [1:4];
    logic [15:0] r_val [1:4];
    logic [7:0] r_flag [1:4];

    logic [RCW-1:0] lc, lnb;
    logic [CCW-1:0] sc, snb;
    logic [12:0] lraw, sraw, wu, wv;
    logic leq, seq;

    logic wr_en;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr [4];
    logic bwe [4];
    logic [BW-1:0] rd [4];

    logic r5_v;
    t_kind r5_kind;
    logic r5_pr, r5_pr1, r5_pc, r5_pc1;

    logic [BW-1:0] d11, d12, d21, d22;
    logic [12:0] omu, omv;
    logic water;

    logic r6_v;
    t_kind r6_kind;
    logic [7:0] r6_flag;
    logic [24:0] r6_w [4];
    logic [SB-1:0] r6_a [4];

    logic r7_v;
    t_kind r7_kind;
    logic [7:0] r7_flag;
    logic [SB-1:0] r7_a11;
    logic [PW-1:0] r7_p [4];

    logic [SW-1:0] sum;
    t_res res;

    assign ws_e = (r_ws == 5'd0) ? 5'd1 : r_ws;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws <= 5'd3;
            r_hw <= 4'd1;
            r_nl <= 13'd4096;
            r_ns <= 13'd4096;
            r_ib <= 3'd0;
            r_wb <= 3'd1;
            r_fb <= 3'd2;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_WINDOW_SIZE: r_ws <= i_cfg_data[4:0];
                CFG_HALF_WINDOW: r_hw <= i_cfg_data[3:0];
                CFG_NUM_LINES: r_nl <= i_cfg_data;
                CFG_NUM_SAMPS: r_ns <= i_cfg_data;
                CFG_INTERP_BIT: r_ib <= i_cfg_data[2:0];
                CFG_WATER_BIT: r_wb <= i_cfg_data[2:0];
                CFG_FILL_BIT: r_fb <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    assign en = !full;
    assign i_item.ready = en;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
            for (int i = 1; i <= 4; i++) begin
                r_v[i] <= 1'b0;
            end
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (en) begin
            r0_v <= i_item.valid;
            r_v[1] <= r0_v;
            for (int i = 2; i <= 4; i++) begin
                r_v[i] <= r_v[i-1];
            end
            r5_v <= r_v[4] && (r_op[4] == OP_INTERP);
            r6_v <= r5_v;
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_op <= i_item.operation;
            r0_line <= i_item.line;
            r0_samp <= i_item.samp;
            r0_fill <= i_item.pixel_is_fill;
            r0_val <= i_item.center_value;
            r0_flag <= i_item.center_flag;
            r_op[1] <= r0_op;
            r_fill[1] <= r0_fill;
            r_val[1] <= r0_val;
            r_flag[1] <= r0_flag;
            for (int i = 2; i <= 4; i++) begin
                r_op[i] <= r_op[i-1];
                r_fill[i] <= r_fill[i-1];
                r_val[i] <= r_val[i-1];
                r_flag[i] <= r_flag[i-1];
            end
        end
    end

    wgbu_axis #(.LIM(GRID_ROWS)) u_axis_line (
        .i_clk(i_clk), .i_en(en), .i_pos(r0_line), .i_n(r_nl), .i_ws(ws_e), .i_hw(r_hw),
        .o_cell(lc), .o_nb(lnb), .o_raw(lraw), .o_eq(leq), .o_w(wu)
    );

    wgbu_axis #(.LIM(GRID_COLS)) u_axis_samp (
        .i_clk(i_clk), .i_en(en), .i_pos(r0_samp), .i_n(r_ns), .i_ws(ws_e), .i_hw(r_hw),
        .o_cell(sc), .o_nb(snb), .o_raw(sraw), .o_eq(seq), .o_w(wv)
    );

    // grid banks, indexed {row parity, column parity}
    assign wr_en = r_v[4] && (r_op[4] == OP_LOAD) &&
                   (int'(lraw) < GRID_ROWS) && (int'(sraw) < GRID_COLS);
    assign waddr = AW'((32'(lraw) >> 1) * HC + (32'(sraw) >> 1));

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            logic [RCW-1:0] rr;
            logic [CCW-1:0] cc;
            rr = (lc[0] == b[1]) ? lc : lnb;
            cc = (sc[0] == b[0]) ? sc : snb;
            raddr[b] = AW'((32'(rr) >> 1) * HC + (32'(cc) >> 1));
            bwe[b] = wr_en && (lraw[0] == b[1]) && (sraw[0] == b[0]);
        end
    end

    for (genvar gb = 0; gb < 4; gb++) begin : g_bank
        wgbu_bank #(.DEPTH(BANK_DEPTH), .W(BW)) u_bank (
            .i_clk(i_clk), .i_en(en), .i_we(bwe[gb]), .i_waddr(waddr),
            .i_wdata({r_flag[4], r_val[4][SB-1:0]}), .i_raddr(raddr[gb]),
            .o_rdata(rd[gb])
        );
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_fill[4]) begin
                r5_kind <= KIND_FILL;
            end else if (leq && seq) begin
                r5_kind <= KIND_CENTER;
            end else begin
                r5_kind <= KIND_INTERP;
            end
            r5_pr <= lc[0];
            r5_pr1 <= lnb[0];
            r5_pc <= sc[0];
            r5_pc1 <= snb[0];
        end
    end

    always_comb begin
        d11 = rd[{r5_pr, r5_pc}];
        d12 = rd[{r5_pr, r5_pc1}];
        d21 = rd[{r5_pr1, r5_pc}];
        d22 = rd[{r5_pr1, r5_pc1}];
        omu = 13'(ONE_Q12) - wu;
        omv = 13'(ONE_Q12) - wv;
        water = |((d11[BW-1:SB] | d12[BW-1:SB] | d21[BW-1:SB] | d22[BW-1:SB]) &
                  (8'd1 << r_wb));
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_kind <= r5_kind;
            unique case (r5_kind)
                KIND_FILL: r6_flag <= 8'd1 << r_fb;
                KIND_CENTER: r6_flag <= d11[BW-1:SB];
                default: r6_flag <= (8'd1 << r_ib) | (water ? (8'd1 << r_wb) : 8'd0);
            endcase
            r6_w[0] <= 25'(omu) * 25'(omv);
            r6_w[1] <= 25'(omu) * 25'(wv);
            r6_w[2] <= 25'(wu) * 25'(omv);
            r6_w[3] <= 25'(wu) * 25'(wv);
            r6_a[0] <= d11[SB-1:0];
            r6_a[1] <= d12[SB-1:0];
            r6_a[2] <= d21[SB-1:0];
            r6_a[3] <= d22[SB-1:0];

            r7_kind <= r6_kind;
            r7_flag <= r6_flag;
            r7_a11 <= r6_a[0];
            for (int i = 0; i < 4; i++) begin
                r7_p[i] <= PW'(r6_w[i]) * PW'(r6_a[i]);
            end
        end
    end

    always_comb begin
        sum = SW'(r7_p[0]) + SW'(r7_p[1]) + SW'(r7_p[2]) + SW'(r7_p[3]) +
              SW'(1 << 23);
        res.flag = r7_flag;
        res.kind = r7_kind;
        unique case (r7_kind)
            KIND_FILL: res.value = 16'd0;
            KIND_CENTER: res.value = 16'(r7_a11);
            default: res.value = 16'(sum >> 24);
        endcase
    end

    wgbu_ofifo u_ofifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(en && r7_v), .i_data(res),
        .o_full(full), .o_result(o_result)
    );

endmodule
`default_nettype wire

// ----- sv/wgbu_axis.sv -----
`default_nettype none
module wgbu_axis #(
    parameter int LIM = 256,
    localparam int CW = $clog2(LIM)
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [11:0]   i_pos,
    input  wire logic [12:0]   i_n,
    input  wire logic [4:0]    i_ws,
    input  wire logic [3:0]    i_hw,
    output logic      [CW-1:0] o_cell,
    output logic      [CW-1:0] o_nb,
    output logic      [12:0]   o_raw,
    output logic               o_eq,
    output logic      [12:0]   o_w
);
    import wgbu_pkg::*;

    localparam logic [12:0] LIMQ = 13'(LIM - 1);

    logic [20:0] rc;

    logic [11:0] r1_pos;
    logic [32:0] r1_pp;
    logic [32:0] r1_np;

    logic [12:0] q, qn, qb;
    logic [CW-1:0] cell_a, cell_b;
    logic [15:0] cl_a, cl_b;
    logic [CW-1:0] r2_cell;
    logic [15:0] r2_cl;
    logic [11:0] r2_pos;
    logic [12:0] r2_raw;

    logic neg;
    logic [15:0] ad;
    logic [CW-1:0] r3_cell;
    logic [15:0] r3_ad;
    logic [36:0] r3_ap;
    logic r3_neg, r3_eq, r3_prv, r3_nxt;
    logic [12:0] r3_raw;

    logic [15:0] qq;
    logic [4:0] rem;
    logic to_prev;
    logic [CW-1:0] r4_cell, r4_nb;
    logic [15:0] r4_x;
    logic r4_eq;
    logic [12:0] r4_raw;

    logic [36:0] r5_wp;

    assign rc = recip(i_ws);

    always_comb begin
        q = r1_pp[32:20];
        qn = r1_np[32:20];
        qb = (qn == 13'd0) ? 13'd0 : qn - 13'd1;
        cell_a = (q > LIMQ) ? CW'(LIM - 1) : q[CW-1:0];
        cell_b = (qb > LIMQ) ? CW'(LIM - 1) : qb[CW-1:0];
        cl_a = 16'(cell_a) * 16'(i_ws) + 16'(i_hw);
        cl_b = 16'(cell_b) * 16'(i_ws) + 16'(i_hw);
        neg = r2_cl > 16'(r2_pos);
        ad = neg ? r2_cl - 16'(r2_pos) : 16'(r2_pos) - r2_cl;
        qq = r3_ap[35:20];
        rem = 5'(r3_ad - 16'(qq * 16'(i_ws)));
        to_prev = r3_neg && (rem != 5'd0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_pos <= i_pos;
            r1_pp <= 33'(i_pos) * 33'(rc);
            r1_np <= 33'(i_n) * 33'(rc);

            r2_pos <= r1_pos;
            r2_raw <= q;
            if (cl_a >= 16'(i_n)) begin
                r2_cell <= cell_b;
                r2_cl <= cl_b;
            end else begin
                r2_cell <= cell_a;
                r2_cl <= cl_a;
            end

            r3_cell <= r2_cell;
            r3_ad <= ad;
            r3_ap <= 37'(ad) * 37'(rc);
            r3_neg <= neg;
            r3_eq <= (r2_cl == 16'(r2_pos));
            r3_prv <= (r2_cl >= 16'(i_ws)) && (r2_cell != '0);
            r3_nxt <= (17'(r2_cl) + 17'(i_ws) + 17'd1 < 17'(i_n)) &&
                      (int'(r2_cell) < LIM - 1);
            r3_raw <= r2_raw;

            r4_cell <= r3_cell;
            if (to_prev) begin
                r4_nb <= r3_prv ? r3_cell - CW'(1) : r3_cell;
            end else begin
                r4_nb <= r3_nxt ? r3_cell + CW'(1) : r3_cell;
            end
            r4_x <= (16'(rem) << 12) + 16'(i_ws >> 1);
            r4_eq <= r3_eq;
            r4_raw <= r3_raw;

            r5_wp <= 37'(r4_x) * 37'(rc);
        end
    end

    assign o_cell = r4_cell;
    assign o_nb = r4_nb;
    assign o_raw = r4_raw;
    assign o_eq = r4_eq;
    assign o_w = r5_wp[32:20];

endmodule
`default_nettype wire

// ----- sv/wgbu_bank.sv -----
`default_nettype none
module wgbu_bank #(
    parameter int DEPTH = 16384,
    parameter int W = 24,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_en && i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_en) begin
            r_rd <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rd;

endmodule
`default_nettype wire

// ----- sv/wgbu_ofifo.sv -----
`default_nettype none
module wgbu_ofifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wgbu_pkg::t_res       i_data,
    output logic                 o_full,
    wgbu_out_if.source           o_result
);
    import wgbu_pkg::*;

    t_res r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic pop;

    assign pop = o_result.valid && o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full = (r_cnt == 2'd2);
    assign o_result.valid = (r_cnt != 2'd0);
    assign o_result.aerosol_value = r_mem[r_rp].value;
    assign o_result.pixel_flag = r_mem[r_rp].flag;
    assign o_result.result_kind = r_mem[r_rp].kind;

endmodule
`default_nettype wire
